/* rtl/bmhpq_pkg.sv */
// Shared package for the binary max-heap priority queue.
// Holds field widths, command and status codes and default sizes.
// No dependencies.
package bmhpq_pkg;

  // Field widths of the request and result items
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 8;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 9;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_W     = ((CMD_W + KEY_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_W    = ((STAT_W + KEY_W + CNT_W + 7) / 8) * 8;

  // Default heap depth and reset value of the capacity limit
  localparam int CAPACITY_DEF = 256;
  localparam logic [CNT_W-1:0] CAP_LIMIT_RST = 9'd256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

endpackage

/* rtl/bmhpq_ram.sv */
// Generic simple RAM: one write port, two registered read ports.
// Used for the heap array storage; no dependencies.
module bmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/binary_max_heap_priority_queue_unit.sv */
// Top level of the binary max-heap priority queue.
// Depends on bmhpq_pkg and bmhpq_ram.
//
// Channel  Dir  Signals                              Content
// in_      in   in_tvalid/in_tready/in_tdata         command, key, index
// out_     out  out_tvalid/out_tready/out_tdata      status, out_key, count
// cfg_     in   cfg_we/cfg_wdata                     capacity_limit
//
// One request at a time. Refused requests and no-op commands skip the sift and go
// via S_FIN to the result register; a sift works one heap level at a time (one
// RAM read, then one compare and write), and each level reads the single heap
// RAM, whose read ports are registered.
// Reset (rst_n low, synchronous) empties the heap and sets the limit to 256.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits at its end for the register to free up.
module binary_max_heap_priority_queue_unit #(
  parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: command[1:0], key[33:2], index[41:34], zero fill above
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bmhpq_pkg::IN_W-1:0]    in_tdata,
  // out_tdata: status[1:0], out_key[33:2], count[42:34], zero fill above
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bmhpq_pkg::OUT_W-1:0]   out_tdata,
  // capacity limit register
  input  logic                          cfg_we,
  input  logic [bmhpq_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = bmhpq_pkg::CNT_W;
  localparam int KEY_W = bmhpq_pkg::KEY_W;
  localparam int PW    = CNT_W + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RD_ROOT = 8'b0000_0010,
    S_RD_OLD  = 8'b0000_0100,
    S_UP_RD   = 8'b0000_1000,
    S_UP_CMP  = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                cap_r;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [KEY_W-1:0]                mov_r, mov_nxt;
  logic [bmhpq_pkg::STAT_W-1:0]    st_r, st_nxt;
  logic [KEY_W-1:0]                rkey_r, rkey_nxt;
  logic                            out_valid_r;
  logic [bmhpq_pkg::STAT_W-1:0]    out_st_r;
  logic [KEY_W-1:0]                out_key_r;
  logic [CNT_W-1:0]                out_cnt_r;

  // Request fields
  logic [bmhpq_pkg::CMD_W-1:0]     in_cmd;
  logic [KEY_W-1:0]                in_key;
  logic [bmhpq_pkg::IDX_W-1:0]     in_idx;
  logic                            in_acc;

  assign in_cmd = in_tdata[1:0];
  assign in_key = in_tdata[33:2];
  assign in_idx = in_tdata[41:34];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid & in_tready;

  // RAM port signals
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [KEY_W-1:0]                ram_wdata, rd_a, rd_b;

  bmhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Effective limit, clipped to the array depth
  logic [CNT_W-1:0] limit;
  always_comb begin
    if (32'(cap_r) > 32'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = cap_r;
    end
  end

  // Tree neighbors of the current hole
  logic [PW-1:0] up_pos, left_pos, right_pos, big_pos;
  logic [KEY_W-1:0] big_key;
  logic          pick_right;
  logic          out_free;

  assign up_pos    = (pos_r - PW'(1)) >> 1;
  assign left_pos  = {pos_r[PW-2:0], 1'b1};
  assign right_pos = left_pos + PW'(1);
  assign pick_right = (right_pos < PW'(count_r)) && ($signed(rd_a) < $signed(rd_b));
  assign big_pos   = pick_right ? right_pos : left_pos;
  assign big_key   = pick_right ? rd_b : rd_a;
  assign out_free  = ~out_valid_r | out_tready;

  // Sequencer: read, compare and write back one heap level at a time
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    mov_nxt     = mov_r;
    st_nxt      = st_r;
    rkey_nxt    = rkey_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(pos_r);
    ram_wdata   = mov_r;
    ram_raddr_a = AW'(pos_r);
    ram_raddr_b = AW'(pos_r);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt    = bmhpq_pkg::ST_OK;
          rkey_nxt  = '0;
          state_nxt = S_FIN;
          case (in_cmd)
            bmhpq_pkg::CMD_INSERT: begin
              if (count_r >= limit) begin
                st_nxt = bmhpq_pkg::ST_FULL;
              end else begin
                mov_nxt   = in_key;
                pos_nxt   = PW'(count_r);
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            bmhpq_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                st_nxt = bmhpq_pkg::ST_EMPTY;
              end else begin
                ram_raddr_a = '0;
                ram_raddr_b = AW'(count_r - CNT_W'(1));
                count_nxt   = count_r - CNT_W'(1);
                state_nxt   = S_RD_ROOT;
              end
            end
            bmhpq_pkg::CMD_CHANGE: begin
              if (CNT_W'(in_idx) >= count_r) begin
                st_nxt = bmhpq_pkg::ST_BADIDX;
              end else begin
                ram_raddr_a = AW'(in_idx);
                mov_nxt     = in_key;
                pos_nxt     = PW'(in_idx);
                state_nxt   = S_RD_OLD;
              end
            end
            default: begin
              st_nxt = bmhpq_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD_ROOT: begin
        // take the root out, move the last entry into the hole at the root
        rkey_nxt  = rd_a;
        mov_nxt   = rd_b;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_RD_OLD: begin
        if ($signed(rd_a) < $signed(mov_r)) begin
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr_a = AW'(up_pos);
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if ($signed(rd_a) < $signed(mov_r)) begin
          // pull the parent down into the hole
          ram_wdata = rd_a;
          pos_nxt   = up_pos;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_RD: begin
        if (pos_r < (PW'(count_r) >> 1)) begin
          ram_raddr_a = AW'(left_pos);
          ram_raddr_b = AW'(right_pos);
          state_nxt   = S_DN_CMP;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if ($signed(mov_r) < $signed(big_key)) begin
          // lift the larger child into the hole
          ram_wdata = big_key;
          pos_nxt   = big_pos;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= bmhpq_pkg::CAP_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    mov_r  <= mov_nxt;
    st_r   <= st_nxt;
    rkey_r <= rkey_nxt;
    if (state_r == S_FIN && out_free) begin
      out_st_r  <= st_r;
      out_key_r <= rkey_r;
      out_cnt_r <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bmhpq_pkg::OUT_W - 43){1'b0}}, out_cnt_r, out_key_r, out_st_r};

endmodule
